[hw/rtl/sfwb_pkg.sv]
`timescale 1ns / 1ps

package sfwb_pkg;

   localparam int POS_W      = 24;
   localparam int DELTA_W    = POS_W + 1;
   localparam int MAG_W      = POS_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int ROOT_W     = 25;
   localparam int LEN_W      = 24;
   localparam int K_W        = 16;
   localparam int K_FRAC     = 8;
   localparam int ADK_W      = MAG_W + K_W;
   localparam int SPLIT_W    = ADK_W / 2;
   localparam int PP_W       = SPLIT_W + ROOT_W;
   localparam int NUM_W      = 65;
   localparam int QUO_W      = 41;
   localparam int MAG_OUT_W  = QUO_W - K_FRAC;
   localparam int FORCE_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int SQRT_LAT   = ROOT_W + 1;
   localparam int DIV_LAT    = QUO_W + 1;
   localparam int TOTAL_LAT  = 8 + SQRT_LAT + DIV_LAT;

   localparam logic [K_W-1:0]     STIFFNESS_RESET  = 16'd256;
   localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 24'hFFFFFF;
   localparam logic [FORCE_W-1:0] FORCE_MAX        = 32'h7FFFFFFF;
   localparam logic [FORCE_W-1:0] FORCE_MIN        = 32'h80000000;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SKIP   = 2'd1,
      STATUS_BROKEN = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFFNESS  = 2'd0,
      CSR_MAX_LENGTH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic             neg_x;
      logic             neg_y;
      logic [MAG_W-1:0] adx;
      logic [MAG_W-1:0] ady;
      logic [LEN_W-1:0] rest;
      logic             pin_a;
      logic             pin_b;
      logic             zero;
   } geom_type;

   typedef struct packed {
      logic       neg_x;
      logic       neg_y;
      logic       pin_a;
      logic       pin_b;
      status_type status;
   } tail_type;

   function automatic logic [FORCE_W-1:0] sat_force(input logic [MAG_OUT_W-1:0] mag,
                                                    input logic neg);
      logic [MAG_OUT_W-1:0] neg_mag;
      logic [FORCE_W-1:0]   res;
      neg_mag = -mag;
      if (!neg) begin
         if (mag > MAG_OUT_W'(FORCE_MAX)) res = FORCE_MAX;
         else res = mag[FORCE_W-1:0];
      end else begin
         if (mag > MAG_OUT_W'(FORCE_MIN)) res = FORCE_MIN;
         else res = neg_mag[FORCE_W-1:0];
      end
      return res;
   endfunction

endpackage

[hw/rtl/sfwb_isqrt.sv]
`timescale 1ns / 1ps

module sfwb_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [sfwb_pkg::SUM_W-1:0]      in_sum,
   output logic                            out_valid,
   output logic [sfwb_pkg::ROOT_W-1:0]     out_root
);

   localparam int RW = sfwb_pkg::ROOT_W;
   localparam int SW = sfwb_pkg::SUM_W;

   logic          vld_ff  [0:RW];
   logic [SW-1:0] rem_ff  [0:RW];
   logic [RW-1:0] root_ff [0:RW];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
      rem_ff[0]  <= in_sum;
      root_ff[0] <= '0;
   end

   for (genvar j = 0; j < RW; j++) begin : g_bit
      localparam int B = RW - 1 - j;
      logic [SW+1:0] trial;
      logic          fit;
      logic [SW-1:0] rem_in;
      logic [RW-1:0] root_in;

      assign trial   = ((SW+2)'(root_ff[j]) << (B + 1)) | ((SW+2)'(1) << (2 * B));
      assign fit     = (SW+2)'(rem_ff[j]) >= trial;
      assign rem_in  = fit ? SW'((SW+2)'(rem_ff[j]) - trial) : rem_ff[j];
      assign root_in = fit ? (root_ff[j] | (RW'(1) << B)) : root_ff[j];

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j+1] <= 1'b0;
         else vld_ff[j+1] <= vld_ff[j];
         rem_ff[j+1]  <= rem_in;
         root_ff[j+1] <= root_in;
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = root_ff[RW];

endmodule

[hw/rtl/sfwb_div.sv]
`timescale 1ns / 1ps

module sfwb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [sfwb_pkg::NUM_W-1:0]      in_num,
   input  logic [sfwb_pkg::ROOT_W-1:0]     in_den,
   output logic                            out_valid,
   output logic [sfwb_pkg::QUO_W-1:0]      out_quo
);

   localparam int QW = sfwb_pkg::QUO_W;
   localparam int DW = sfwb_pkg::ROOT_W;
   localparam int NW = sfwb_pkg::NUM_W;

   logic          vld_ff [0:QW];
   logic [DW-1:0] r_ff   [0:QW];
   logic [QW-1:0] nq_ff  [0:QW];
   logic [DW-1:0] den_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
      r_ff[0]   <= DW'(in_num[NW-1:QW]);
      nq_ff[0]  <= in_num[QW-1:0];
      den_ff[0] <= in_den;
   end

   for (genvar j = 0; j < QW; j++) begin : g_bit
      logic [DW:0]   t;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] r_in;
      logic [QW-1:0] nq_in;

      assign t     = {r_ff[j], nq_ff[j][QW-1]};
      assign ge    = t >= {1'b0, den_ff[j]};
      assign diff  = t - {1'b0, den_ff[j]};
      assign r_in  = ge ? diff[DW-1:0] : t[DW-1:0];
      assign nq_in = {nq_ff[j][QW-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) vld_ff[j+1] <= 1'b0;
         else vld_ff[j+1] <= vld_ff[j];
         r_ff[j+1]   <= r_in;
         nq_ff[j+1]  <= nq_in;
         den_ff[j+1] <= den_ff[j];
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = nq_ff[QW];

endmodule

[hw/rtl/spring_force_with_break_unit.sv]
`timescale 1ns / 1ps

// Evaluates one 2D spring per transaction and accepts a new one on every clock cycle;
// busy is high only during reset. Each result appears on the rsp_ ports for one cycle,
// marked by rsp_valid, once it has passed the stage registers, the bit-serial square root
// (26 stages) and the force divider (42 stages); the receiver must take it then.
// Configuration writes are always ready and should be made while no transaction is in flight.

module spring_force_with_break_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sfwb_pkg::POS_W-1:0]   req_a_x,
   input  logic signed [sfwb_pkg::POS_W-1:0]   req_a_y,
   input  logic signed [sfwb_pkg::POS_W-1:0]   req_b_x,
   input  logic signed [sfwb_pkg::POS_W-1:0]   req_b_y,
   input  logic [sfwb_pkg::LEN_W-1:0]          req_rest_length,
   input  logic                                req_a_pinned,
   input  logic                                req_b_pinned,
   output logic                                rsp_valid,
   output logic signed [sfwb_pkg::FORCE_W-1:0] rsp_force_a_x,
   output logic signed [sfwb_pkg::FORCE_W-1:0] rsp_force_a_y,
   output logic signed [sfwb_pkg::FORCE_W-1:0] rsp_force_b_x,
   output logic signed [sfwb_pkg::FORCE_W-1:0] rsp_force_b_y,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfwb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfwb_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DW  = sfwb_pkg::DELTA_W;
   localparam int MW  = sfwb_pkg::MAG_W;
   localparam int RW  = sfwb_pkg::ROOT_W;
   localparam int LW  = sfwb_pkg::LEN_W;
   localparam int KW  = sfwb_pkg::K_W;
   localparam int AW  = sfwb_pkg::ADK_W;
   localparam int SPW = sfwb_pkg::SPLIT_W;
   localparam int PW  = sfwb_pkg::PP_W;
   localparam int NW  = sfwb_pkg::NUM_W;
   localparam int QW  = sfwb_pkg::QUO_W;
   localparam int FW  = sfwb_pkg::FORCE_W;

   logic accept;

   logic [KW-1:0] stiffness_ff;
   logic [LW-1:0] max_length_ff;

   assign busy      = reset;
   assign accept    = start & ~busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff  <= sfwb_pkg::STIFFNESS_RESET;
         max_length_ff <= sfwb_pkg::MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == sfwb_pkg::CSR_STIFFNESS) stiffness_ff <= csr_data[KW-1:0];
         if (csr_index == sfwb_pkg::CSR_MAX_LENGTH) max_length_ff <= csr_data[LW-1:0];
      end
   end

   // stage 1: deltas
   logic                 v1_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff;
   logic [LW-1:0]        rest1_ff;
   logic                 pin_a1_ff, pin_b1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= accept;
      dx1_ff    <= {req_b_x[MW-1], req_b_x} - {req_a_x[MW-1], req_a_x};
      dy1_ff    <= {req_b_y[MW-1], req_b_y} - {req_a_y[MW-1], req_a_y};
      rest1_ff  <= req_rest_length;
      pin_a1_ff <= req_a_pinned;
      pin_b1_ff <= req_b_pinned;
   end

   // stage 2: magnitudes
   logic                v2_ff;
   sfwb_pkg::geom_type  geom2_ff, geom2_in;
   logic [DW-1:0]       adx_full, ady_full;

   assign adx_full = dx1_ff[DW-1] ? DW'(-dx1_ff) : DW'(dx1_ff);
   assign ady_full = dy1_ff[DW-1] ? DW'(-dy1_ff) : DW'(dy1_ff);

   always_comb begin
      geom2_in.neg_x = dx1_ff[DW-1];
      geom2_in.neg_y = dy1_ff[DW-1];
      geom2_in.adx   = adx_full[MW-1:0];
      geom2_in.ady   = ady_full[MW-1:0];
      geom2_in.rest  = rest1_ff;
      geom2_in.pin_a = pin_a1_ff;
      geom2_in.pin_b = pin_b1_ff;
      geom2_in.zero  = (dx1_ff == '0) && (dy1_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      geom2_ff <= geom2_in;
   end

   // stage 3: squares
   logic                         v3_ff;
   sfwb_pkg::geom_type           geom3_ff;
   logic [sfwb_pkg::SQ_W-1:0]    sqx3_ff, sqy3_ff;
   logic [sfwb_pkg::SUM_W-1:0]   sum3;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      geom3_ff <= geom2_ff;
      sqx3_ff  <= geom2_ff.adx * geom2_ff.adx;
      sqy3_ff  <= geom2_ff.ady * geom2_ff.ady;
   end

   assign sum3 = sfwb_pkg::SUM_W'(sqx3_ff) + sfwb_pkg::SUM_W'(sqy3_ff);

   // square root with matching side line
   logic               sq_valid;
   logic [RW-1:0]      sq_root;
   sfwb_pkg::geom_type geom_dly_ff [0:sfwb_pkg::SQRT_LAT-1];

   sfwb_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_sum    (sum3),
      .out_valid (sq_valid),
      .out_root  (sq_root)
   );

   always_ff @(posedge clock) begin
      geom_dly_ff[0] <= geom3_ff;
      for (int i = 1; i < sfwb_pkg::SQRT_LAT; i++) geom_dly_ff[i] <= geom_dly_ff[i-1];
   end

   // stage 4: stretch and break test
   sfwb_pkg::geom_type g4;
   logic [RW:0]        stretch;
   logic [RW:0]        abs_stretch;
   logic               sneg;
   logic               broken;
   sfwb_pkg::tail_type tail4_in;

   logic               v4_ff;
   sfwb_pkg::tail_type tail4_ff;
   logic [RW-1:0]      dist4_ff, as4_ff;
   logic [MW-1:0]      adx4_ff, ady4_ff;

   assign g4          = geom_dly_ff[sfwb_pkg::SQRT_LAT-1];
   assign stretch     = {1'b0, sq_root} - (RW+1)'(g4.rest);
   assign sneg        = stretch[RW];
   assign abs_stretch = sneg ? -stretch : stretch;
   assign broken      = sq_root > RW'(max_length_ff);

   always_comb begin
      tail4_in.neg_x = g4.neg_x ^ sneg;
      tail4_in.neg_y = g4.neg_y ^ sneg;
      tail4_in.pin_a = g4.pin_a;
      tail4_in.pin_b = g4.pin_b;
      if (g4.zero) tail4_in.status = sfwb_pkg::STATUS_SKIP;
      else if (broken) tail4_in.status = sfwb_pkg::STATUS_BROKEN;
      else tail4_in.status = sfwb_pkg::STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= sq_valid;
      tail4_ff <= tail4_in;
      dist4_ff <= sq_root;
      as4_ff   <= abs_stretch[RW-1:0];
      adx4_ff  <= g4.adx;
      ady4_ff  <= g4.ady;
   end

   // stage 5: delta times stiffness
   logic               v5_ff;
   sfwb_pkg::tail_type tail5_ff;
   logic [RW-1:0]      dist5_ff, as5_ff;
   logic [AW-1:0]      adkx5_ff, adky5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      tail5_ff <= tail4_ff;
      dist5_ff <= dist4_ff;
      as5_ff   <= as4_ff;
      adkx5_ff <= adx4_ff * stiffness_ff;
      adky5_ff <= ady4_ff * stiffness_ff;
   end

   // stage 6: partial products with stretch
   logic               v6_ff;
   sfwb_pkg::tail_type tail6_ff;
   logic [RW-1:0]      dist6_ff;
   logic [PW-1:0]      plox6_ff, phix6_ff, ploy6_ff, phiy6_ff;

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      tail6_ff <= tail5_ff;
      dist6_ff <= dist5_ff;
      plox6_ff <= adkx5_ff[SPW-1:0] * as5_ff;
      phix6_ff <= adkx5_ff[AW-1:SPW] * as5_ff;
      ploy6_ff <= adky5_ff[SPW-1:0] * as5_ff;
      phiy6_ff <= adky5_ff[AW-1:SPW] * as5_ff;
   end

   // stage 7: full numerators
   logic               v7_ff;
   sfwb_pkg::tail_type tail7_ff;
   logic [RW-1:0]      dist7_ff;
   logic [NW-1:0]      numx7_ff, numy7_ff;

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6_ff;
      tail7_ff <= tail6_ff;
      dist7_ff <= dist6_ff;
      numx7_ff <= NW'(plox6_ff) + (NW'(phix6_ff) << SPW);
      numy7_ff <= NW'(ploy6_ff) + (NW'(phiy6_ff) << SPW);
   end

   // division by length
   logic               dvx_valid, dvy_valid;
   logic [QW-1:0]      quo_x, quo_y;
   sfwb_pkg::tail_type tail_dly_ff [0:sfwb_pkg::DIV_LAT-1];

   sfwb_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num    (numx7_ff),
      .in_den    (dist7_ff),
      .out_valid (dvx_valid),
      .out_quo   (quo_x)
   );

   sfwb_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v7_ff),
      .in_num    (numy7_ff),
      .in_den    (dist7_ff),
      .out_valid (dvy_valid),
      .out_quo   (quo_y)
   );

   always_ff @(posedge clock) begin
      tail_dly_ff[0] <= tail7_ff;
      for (int i = 1; i < sfwb_pkg::DIV_LAT; i++) tail_dly_ff[i] <= tail_dly_ff[i-1];
   end

   // stage 8: saturate and mask
   sfwb_pkg::tail_type t8;
   logic               apply;
   logic [FW-1:0]      fax_in, fay_in, fbx_in, fby_in;

   logic               rsp_valid_ff;
   logic [FW-1:0]      fax_ff, fay_ff, fbx_ff, fby_ff;
   logic [1:0]         status_ff;

   assign t8    = tail_dly_ff[sfwb_pkg::DIV_LAT-1];
   assign apply = (t8.status == sfwb_pkg::STATUS_OK);

   always_comb begin
      fax_in = '0;
      fay_in = '0;
      fbx_in = '0;
      fby_in = '0;
      if (apply && !t8.pin_a) begin
         fax_in = sfwb_pkg::sat_force(quo_x[QW-1:sfwb_pkg::K_FRAC], t8.neg_x);
         fay_in = sfwb_pkg::sat_force(quo_y[QW-1:sfwb_pkg::K_FRAC], t8.neg_y);
      end
      if (apply && !t8.pin_b) begin
         fbx_in = sfwb_pkg::sat_force(quo_x[QW-1:sfwb_pkg::K_FRAC], !t8.neg_x);
         fby_in = sfwb_pkg::sat_force(quo_y[QW-1:sfwb_pkg::K_FRAC], !t8.neg_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= dvx_valid & dvy_valid;
      fax_ff    <= fax_in;
      fay_ff    <= fay_in;
      fbx_ff    <= fbx_in;
      fby_ff    <= fby_in;
      status_ff <= t8.status;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_force_a_x = fax_ff;
   assign rsp_force_a_y = fay_ff;
   assign rsp_force_b_x = fbx_ff;
   assign rsp_force_b_y = fby_ff;
   assign rsp_status    = status_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(sfwb_pkg::TOTAL_LAT) rsp_valid)
      else $error("transaction result missing");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, sfwb_pkg::TOTAL_LAT))
      else $error("result without transaction");

   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      dvx_valid == dvy_valid)
      else $error("divider lanes out of step");

   a_idle_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sfwb_pkg::STATUS_OK) |->
         (rsp_force_a_x == '0) && (rsp_force_a_y == '0) &&
         (rsp_force_b_x == '0) && (rsp_force_b_y == '0))
      else $error("force on skipped or broken spring");

   a_opposite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sfwb_pkg::STATUS_OK) &&
      (rsp_force_a_x != '0) && (rsp_force_b_x != '0) |->
         (FW'(rsp_force_a_x + rsp_force_b_x) == '0) ||
         ((rsp_force_a_x == sfwb_pkg::FORCE_MAX) && (rsp_force_b_x == sfwb_pkg::FORCE_MIN)) ||
         ((rsp_force_a_x == sfwb_pkg::FORCE_MIN) && (rsp_force_b_x == sfwb_pkg::FORCE_MAX)))
      else $error("endpoint forces not opposite");

endmodule
